// ----- hdl/bat_pkg.sv -----
// ----------------------------------------------------------------------------
// Bearing angle package
// Shared widths, turn constants, quadrant flags and the CORDIC arctangent
// table for the two-point bearing unit.
// ----------------------------------------------------------------------------
package bat_pkg;

  localparam int COORD_WIDTH  = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_WIDTH  = 16;

  localparam int ATAN_ENTRIES = 24;
  localparam int NUM_STEPS    = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

  localparam int DIFF_WIDTH = COORD_WIDTH + 1;
  localparam int MAG_WIDTH  = COORD_WIDTH;
  localparam int XY_WIDTH   = COORD_WIDTH + CORDIC_STEPS + 3;
  localparam int TURN_WIDTH = 32;
  localparam int Z_WIDTH    = TURN_WIDTH + 1;

  localparam logic [TURN_WIDTH-1:0] TURN_QUARTER  = 32'h4000_0000;
  localparam logic [TURN_WIDTH-1:0] TURN_3QUARTER = 32'hC000_0000;
  localparam logic [TURN_WIDTH-1:0] ROUND_HALF    =
    TURN_WIDTH'(64'd1 << (TURN_WIDTH - 1 - ANGLE_WIDTH));

  typedef struct packed {
    logic dx_neg;
    logic dx_zero;
    logic dy_pos;
    logic dy_zero;
  } quad_t;

  function automatic logic [Z_WIDTH-1:0] atan_entry(input int idx);
    logic [31:0] val;
    case (idx)
      0:       val = 32'd536870912;
      1:       val = 32'd316933406;
      2:       val = 32'd167458907;
      3:       val = 32'd85004756;
      4:       val = 32'd42667331;
      5:       val = 32'd21354465;
      6:       val = 32'd10679838;
      7:       val = 32'd5340245;
      8:       val = 32'd2670163;
      9:       val = 32'd1335087;
      10:      val = 32'd667544;
      11:      val = 32'd333772;
      12:      val = 32'd166886;
      13:      val = 32'd83443;
      14:      val = 32'd41722;
      15:      val = 32'd20861;
      16:      val = 32'd10430;
      17:      val = 32'd5215;
      18:      val = 32'd2608;
      19:      val = 32'd1304;
      20:      val = 32'd652;
      21:      val = 32'd326;
      22:      val = 32'd163;
      23:      val = 32'd81;
      default: val = 32'd0;
    endcase
    return Z_WIDTH'(val);
  endfunction

endpackage

// ----- hdl/bat_prep.sv -----
// ----------------------------------------------------------------------------
// Bearing angle input stage
// Forms the point difference, its magnitudes scaled to the CORDIC format and
// the quadrant flags, and registers them.
// ----------------------------------------------------------------------------
module bat_prep (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     adv_i,
  input  logic                                     valid_i,
  input  logic signed [bat_pkg::COORD_WIDTH-1:0]   a_x_i,
  input  logic signed [bat_pkg::COORD_WIDTH-1:0]   a_y_i,
  input  logic signed [bat_pkg::COORD_WIDTH-1:0]   b_x_i,
  input  logic signed [bat_pkg::COORD_WIDTH-1:0]   b_y_i,
  output logic                                     valid_o,
  output logic signed [bat_pkg::XY_WIDTH-1:0]      x_o,
  output logic signed [bat_pkg::XY_WIDTH-1:0]      y_o,
  output bat_pkg::quad_t                           quad_o
);
  import bat_pkg::*;

  logic signed [DIFF_WIDTH-1:0] dx, dy;
  logic signed [DIFF_WIDTH-1:0] dx_abs, dy_abs;
  logic [MAG_WIDTH-1:0]         mag_x, mag_y;
  logic                         valid_q;
  logic signed [XY_WIDTH-1:0]   x_q, y_q;
  quad_t                        quad_d, quad_q;

  always_comb begin
    dx     = DIFF_WIDTH'(a_x_i) - DIFF_WIDTH'(b_x_i);
    dy     = DIFF_WIDTH'(a_y_i) - DIFF_WIDTH'(b_y_i);
    dx_abs = dx[DIFF_WIDTH-1] ? -dx : dx;
    dy_abs = dy[DIFF_WIDTH-1] ? -dy : dy;
    mag_x  = dx_abs[MAG_WIDTH-1:0];
    mag_y  = dy_abs[MAG_WIDTH-1:0];
    quad_d.dx_neg  = dx[DIFF_WIDTH-1];
    quad_d.dx_zero = (dx == '0);
    quad_d.dy_pos  = !dy[DIFF_WIDTH-1] && (dy != '0);
    quad_d.dy_zero = (dy == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      x_q    <= XY_WIDTH'({mag_x, {CORDIC_STEPS{1'b0}}});
      y_q    <= XY_WIDTH'({mag_y, {CORDIC_STEPS{1'b0}}});
      quad_q <= quad_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign quad_o  = quad_q;

endmodule

// ----- hdl/bat_cordic.sv -----
// ----------------------------------------------------------------------------
// Bearing angle CORDIC pipeline
// Vectoring CORDIC in the first quadrant, one register stage per iteration,
// accumulating the arctangent in units of a full turn over 2^32.
// ----------------------------------------------------------------------------
module bat_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic                                valid_i,
  input  logic signed [bat_pkg::XY_WIDTH-1:0] x_i,
  input  logic signed [bat_pkg::XY_WIDTH-1:0] y_i,
  input  bat_pkg::quad_t                      quad_i,
  output logic                                valid_o,
  output logic signed [bat_pkg::Z_WIDTH-1:0]  z_o,
  output bat_pkg::quad_t                      quad_o
);
  import bat_pkg::*;

  logic                       valid_s [0:NUM_STEPS];
  logic signed [Z_WIDTH-1:0]  z_s     [0:NUM_STEPS];
  quad_t                      quad_s  [0:NUM_STEPS];
  logic signed [XY_WIDTH-1:0] x_s     [0:NUM_STEPS-1];
  logic signed [XY_WIDTH-1:0] y_s     [0:NUM_STEPS-1];

  assign valid_s[0] = valid_i;
  assign z_s[0]     = '0;
  assign quad_s[0]  = quad_i;
  assign x_s[0]     = x_i;
  assign y_s[0]     = y_i;

  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
    logic                      rot_down;
    logic signed [Z_WIDTH-1:0] z_d;
    logic signed [Z_WIDTH-1:0] z_q;
    logic                      valid_q;
    quad_t                     quad_q;

    assign rot_down = !y_s[i][XY_WIDTH-1];
    assign z_d      = rot_down ? z_s[i] + $signed(atan_entry(i))
                               : z_s[i] - $signed(atan_entry(i));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q <= 1'b0;
      end else if (adv_i) begin
        valid_q <= valid_s[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i && valid_s[i]) begin
        z_q    <= z_d;
        quad_q <= quad_s[i];
      end
    end

    assign valid_s[i+1] = valid_q;
    assign z_s[i+1]     = z_q;
    assign quad_s[i+1]  = quad_q;

    if (i < NUM_STEPS - 1) begin : g_vec
      logic signed [XY_WIDTH-1:0] xs, ys, x_d, y_d, x_q, y_q;

      always_comb begin
        xs = x_s[i] >>> i;
        ys = y_s[i] >>> i;
        if (rot_down) begin
          x_d = x_s[i] + ys;
          y_d = y_s[i] - xs;
        end else begin
          x_d = x_s[i] - ys;
          y_d = y_s[i] + xs;
        end
      end

      always_ff @(posedge clk_i) begin
        if (adv_i && valid_s[i]) begin
          x_q <= x_d;
          y_q <= y_d;
        end
      end

      assign x_s[i+1] = x_q;
      assign y_s[i+1] = y_q;
    end
  end

  assign valid_o = valid_s[NUM_STEPS];
  assign z_o     = z_s[NUM_STEPS];
  assign quad_o  = quad_s[NUM_STEPS];

endmodule

// ----- hdl/bat_quadrant.sv -----
// ----------------------------------------------------------------------------
// Bearing angle output stage
// Applies the quadrant rules and the axis special cases to the arctangent,
// rounds to the output angle width and holds the result register.
// ----------------------------------------------------------------------------
module bat_quadrant (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic                                valid_i,
  input  logic signed [bat_pkg::Z_WIDTH-1:0]  z_i,
  input  bat_pkg::quad_t                      quad_i,
  output logic                                valid_o,
  output logic [bat_pkg::ANGLE_WIDTH-1:0]     angle_o,
  output logic                                coincident_o
);
  import bat_pkg::*;

  logic [TURN_WIDTH-1:0]  t, full, rounded;
  logic                   coinc_d;
  logic [ANGLE_WIDTH-1:0] angle_d;
  logic                   valid_q;
  logic [ANGLE_WIDTH-1:0] angle_q;
  logic                   coinc_q;

  always_comb begin
    coinc_d = quad_i.dx_zero && quad_i.dy_zero;
    if (quad_i.dx_zero) begin
      t = TURN_QUARTER;
    end else if (quad_i.dy_zero) begin
      t = '0;
    end else begin
      t = z_i[TURN_WIDTH-1:0];
    end
    if (!quad_i.dx_neg && !quad_i.dy_pos) begin
      full = TURN_QUARTER - t;
    end else if (!quad_i.dx_neg && !quad_i.dx_zero) begin
      full = TURN_QUARTER + t;
    end else if (quad_i.dy_pos) begin
      full = TURN_3QUARTER - t;
    end else begin
      full = TURN_3QUARTER + t;
    end
    rounded = full + ROUND_HALF;
    angle_d = coinc_d ? '0 : rounded[TURN_WIDTH-1 -: ANGLE_WIDTH];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      angle_q <= angle_d;
      coinc_q <= coinc_d;
    end
  end

  assign valid_o      = valid_q;
  assign angle_o      = angle_q;
  assign coincident_o = coinc_q;

endmodule

// ----- hdl/bearing_angle_two_points_unit.sv -----
// ----------------------------------------------------------------------------
// Two-point bearing unit
// Returns the bearing of point A as seen from point B as a binary angle.
// ----------------------------------------------------------------------------
// The unit accepts one point pair per clock cycle while its input is not
// stalled and returns one request per pair, in order, after one input stage,
// one register stage for each CORDIC iteration and one output stage. A stall
// on the output holds the whole pipeline in place, so no request is lost or
// repeated; the unit stalls its input only while the output register holds a
// request that is not taken.
// Coincident points give an angle of zero with the coincident flag set.
module bearing_angle_two_points_unit (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic signed [bat_pkg::COORD_WIDTH-1:0]   a_x_i,
  input  logic signed [bat_pkg::COORD_WIDTH-1:0]   a_y_i,
  input  logic signed [bat_pkg::COORD_WIDTH-1:0]   b_x_i,
  input  logic signed [bat_pkg::COORD_WIDTH-1:0]   b_y_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic [bat_pkg::ANGLE_WIDTH-1:0]          angle_o,
  output logic                                     coincident_o
);
  import bat_pkg::*;

  logic                       adv;
  logic                       prep_valid, cordic_valid;
  logic signed [XY_WIDTH-1:0] prep_x, prep_y;
  quad_t                      prep_quad, cordic_quad;
  logic signed [Z_WIDTH-1:0]  cordic_z;

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  bat_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .a_x_i   (a_x_i),
    .a_y_i   (a_y_i),
    .b_x_i   (b_x_i),
    .b_y_i   (b_y_i),
    .valid_o (prep_valid),
    .x_o     (prep_x),
    .y_o     (prep_y),
    .quad_o  (prep_quad)
  );

  bat_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (prep_valid),
    .x_i     (prep_x),
    .y_i     (prep_y),
    .quad_i  (prep_quad),
    .valid_o (cordic_valid),
    .z_o     (cordic_z),
    .quad_o  (cordic_quad)
  );

  bat_quadrant u_quadrant (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .valid_i      (cordic_valid),
    .z_i          (cordic_z),
    .quad_i       (cordic_quad),
    .valid_o      (out_valid_o),
    .angle_o      (angle_o),
    .coincident_o (coincident_o)
  );

endmodule

// ----- test/bearing_angle_two_points_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Two-point bearing unit testbench
// Drives point pairs through the bearing unit with random input gaps and
// output stalls. Every result is checked, in order, against a bit-exact
// CORDIC bearing predictor. A short table of directed pairs comes first,
// covering coincident points, pure vertical and horizontal offsets, all four
// quadrants and the coordinate extremes. A long random run follows.
// ----------------------------------------------------------------------------
module bearing_angle_two_points_unit_tb;

  import bat_pkg::*;

  localparam int    RANDOM_PAIRS = 1530;
  localparam int    QUIET_PAIRS  = 150;
  localparam int    CYCLE_LIMIT  = 400000;
  localparam int    ATAN_SIZE    = 24;
  localparam longint QUARTER_TURN  = 64'h4000_0000;
  localparam longint THREE_QUARTER = 64'hC000_0000;

  localparam longint ATAN_TURNS [ATAN_SIZE] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct packed {
    logic [ANGLE_WIDTH-1:0] angle;
    logic                   coincident;
  } bearing_t;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by;
    logic                          typed;
    bearing_t                      want;
  } pair_row_t;

  logic                          clk_i        = 1'b0;
  logic                          rst_ni       = 1'b0;
  logic                          in_valid_i   = 1'b0;
  logic                          in_stall_o;
  logic signed [COORD_WIDTH-1:0] a_x_i        = '0;
  logic signed [COORD_WIDTH-1:0] a_y_i        = '0;
  logic signed [COORD_WIDTH-1:0] b_x_i        = '0;
  logic signed [COORD_WIDTH-1:0] b_y_i        = '0;
  logic                          out_valid_o;
  logic                          out_stall_i  = 1'b0;
  logic [ANGLE_WIDTH-1:0]        angle_o;
  logic                          coincident_o;

  bearing_t  pending_bearings [$];
  pair_row_t directed_pairs [$];
  bearing_t  oldest_bearing;
  int        errors          = 0;
  int        checked_count   = 0;
  int        coincident_seen = 0;
  int        cycle_count     = 0;
  int        stall_left      = 0;
  logic      idling_on       = 1'b1;

  bearing_angle_two_points_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .a_x_i        (a_x_i),
    .a_y_i        (a_y_i),
    .b_x_i        (b_x_i),
    .b_y_i        (b_y_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .angle_o      (angle_o),
    .coincident_o (coincident_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d requests outstanding", $time, pending_bearings.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic bearing_t bearing_of(input logic signed [COORD_WIDTH-1:0] ax,
                                          input logic signed [COORD_WIDTH-1:0] ay,
                                          input logic signed [COORD_WIDTH-1:0] bx,
                                          input logic signed [COORD_WIDTH-1:0] by);
    longint   dx;
    longint   dy;
    longint   x;
    longint   y;
    longint   xs;
    longint   ys;
    longint   z;
    longint   full;
    logic [31:0] turn;
    bearing_t r;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    r.coincident = 1'b0;
    if (dx == 0 && dy == 0) begin
      r.angle      = '0;
      r.coincident = 1'b1;
      return r;
    end
    if (dx == 0) begin
      z = QUARTER_TURN;
    end else if (dy == 0) begin
      z = 0;
    end else begin
      x = (dx < 0 ? -dx : dx) <<< CORDIC_STEPS;
      y = (dy < 0 ? -dy : dy) <<< CORDIC_STEPS;
      z = 0;
      for (int i = 0; i < CORDIC_STEPS && i < ATAN_SIZE; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_TURNS[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_TURNS[i];
        end
      end
    end
    if (dx >= 0 && dy <= 0) begin
      full = QUARTER_TURN - z;
    end else if (dx > 0) begin
      full = QUARTER_TURN + z;
    end else if (dy > 0) begin
      full = THREE_QUARTER - z;
    end else begin
      full = THREE_QUARTER + z;
    end
    turn    = full[31:0] + (32'd1 << (31 - ANGLE_WIDTH));
    r.angle = turn[31:32-ANGLE_WIDTH];
    return r;
  endfunction

  task automatic add_row(input int ax, input int ay, input int bx, input int by,
                         input logic typed, input int angle, input logic coin);
    pair_row_t row;
    row.ax              = COORD_WIDTH'(ax);
    row.ay              = COORD_WIDTH'(ay);
    row.bx              = COORD_WIDTH'(bx);
    row.by              = COORD_WIDTH'(by);
    row.typed           = typed;
    row.want.angle      = ANGLE_WIDTH'(angle);
    row.want.coincident = coin;
    directed_pairs.push_back(row);
  endtask

  task automatic send_pair(input logic signed [COORD_WIDTH-1:0] ax,
                           input logic signed [COORD_WIDTH-1:0] ay,
                           input logic signed [COORD_WIDTH-1:0] bx,
                           input logic signed [COORD_WIDTH-1:0] by,
                           input bearing_t want);
    logic accepted;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    a_x_i      <= ax;
    a_y_i      <= ay;
    b_x_i      <= bx;
    b_y_i      <= by;
    accepted = 1'b0;
    while (!accepted) begin
      @(negedge clk_i);
      accepted = !in_stall_o;
      @(posedge clk_i);
    end
    pending_bearings.push_back(want);
  endtask

  function automatic int offset_from(input int base, input int delta);
    int v;
    v = base + delta;
    if (v > 32767 || v < -32768) v = base - delta;
    return v;
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(0, 4))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni || !idling_on) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  = $urandom_range(0, 15);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_bearings.size() == 0) begin
        errors++;
        $display("%0t: request with none expected: angle %h coincident %b",
                 $time, angle_o, coincident_o);
      end else begin
        oldest_bearing = pending_bearings.pop_front();
        checked_count++;
        if (oldest_bearing.coincident) coincident_seen++;
        if (angle_o !== oldest_bearing.angle) begin
          errors++;
          $display("%0t: angle mismatch: expected %h, actual %h",
                   $time, oldest_bearing.angle, angle_o);
        end
        if (coincident_o !== oldest_bearing.coincident) begin
          errors++;
          $display("%0t: coincident mismatch: expected %b, actual %b",
                   $time, oldest_bearing.coincident, coincident_o);
        end
      end
    end
  end

  initial begin
    int       kind;
    int       ax;
    int       ay;
    int       bx;
    int       by;
    int       d;
    bearing_t want;

    add_row(0, 0, 0, 0, 1'b1, 0, 1'b1);
    add_row(-32768, -32768, -32768, -32768, 1'b1, 0, 1'b1);
    add_row(32767, 32767, 32767, 32767, 1'b1, 0, 1'b1);
    add_row(0, -5, 0, 0, 1'b1, 16'h0000, 1'b0);
    add_row(0, 5, 0, 0, 1'b1, 16'h8000, 1'b0);
    add_row(7, 0, 0, 0, 1'b1, 16'h4000, 1'b0);
    add_row(-7, 0, 0, 0, 1'b1, 16'hC000, 1'b0);
    add_row(32767, 0, -32768, 0, 1'b1, 16'h4000, 1'b0);
    add_row(-32768, 0, 32767, 0, 1'b1, 16'hC000, 1'b0);
    add_row(0, -32768, 0, 32767, 1'b1, 16'h0000, 1'b0);
    add_row(0, 32767, 0, -32768, 1'b1, 16'h8000, 1'b0);
    add_row(3, -4, 0, 0, 1'b0, 0, 1'b0);
    add_row(3, 4, 0, 0, 1'b0, 0, 1'b0);
    add_row(-3, 4, 0, 0, 1'b0, 0, 1'b0);
    add_row(-3, -4, 0, 0, 1'b0, 0, 1'b0);
    add_row(1, 1, 0, 0, 1'b0, 0, 1'b0);
    add_row(-1, -1, 0, 0, 1'b0, 0, 1'b0);
    add_row(32767, 32767, -32768, -32768, 1'b0, 0, 1'b0);
    add_row(-32768, 32767, 32767, -32768, 1'b0, 0, 1'b0);
    add_row(32767, -32768, -32768, 32767, 1'b0, 0, 1'b0);
    add_row(-32768, -32768, 32767, 32767, 1'b0, 0, 1'b0);
    add_row(1, -32768, 0, 32767, 1'b0, 0, 1'b0);
    add_row(-1, -32768, 0, 32767, 1'b0, 0, 1'b0);
    add_row(32767, 1, -32768, 0, 1'b0, 0, 1'b0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (directed_pairs[i]) begin
      if (directed_pairs[i].typed) begin
        want = directed_pairs[i].want;
      end else begin
        want = bearing_of(directed_pairs[i].ax, directed_pairs[i].ay,
                          directed_pairs[i].bx, directed_pairs[i].by);
      end
      send_pair(directed_pairs[i].ax, directed_pairs[i].ay,
                directed_pairs[i].bx, directed_pairs[i].by, want);
    end

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      idling_on = (n < RANDOM_PAIRS - QUIET_PAIRS) && ((n / 100) % 3 != 2);
      kind = $urandom_range(0, 9);
      bx   = int'($signed(16'($urandom)));
      by   = int'($signed(16'($urandom)));
      ax   = int'($signed(16'($urandom)));
      ay   = int'($signed(16'($urandom)));
      case (kind)
        5, 6: begin
          ax = offset_from(bx, $urandom_range(0, 40) - 20);
          ay = offset_from(by, $urandom_range(0, 40) - 20);
        end
        7: begin
          if ($urandom_range(0, 1) == 0) ax = bx;
          else ay = by;
        end
        8: begin
          if ($urandom_range(0, 2) == 0) begin
            ax = bx;
            ay = by;
          end else begin
            d  = $urandom_range(1, 2000);
            ax = offset_from(bx, $urandom_range(0, 1) ? d : -d);
            ay = offset_from(by, $urandom_range(0, 1) ? d : -d);
          end
        end
        9: begin
          ax = extreme_coord();
          ay = extreme_coord();
          bx = extreme_coord();
          by = extreme_coord();
        end
        default: ;
      endcase
      want = bearing_of(COORD_WIDTH'(ax), COORD_WIDTH'(ay), COORD_WIDTH'(bx), COORD_WIDTH'(by));
      send_pair(COORD_WIDTH'(ax), COORD_WIDTH'(ay), COORD_WIDTH'(bx), COORD_WIDTH'(by), want);
    end
    in_valid_i <= 1'b0;

    while (pending_bearings.size() != 0) @(posedge clk_i);
    repeat (NUM_STEPS + 8) @(posedge clk_i);

    $display("Checked %0d bearing requests, %0d directed and %0d with coincident points,",
             checked_count, directed_pairs.size(), coincident_seen);
    $display("under random input gaps and output stalls; %0d mismatches.", errors);
    if (errors == 0 && pending_bearings.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
